@@ rtl/iidl_pkg.sv @@
// Shared types and constants for the indexed insert/delete list.
package iidl_pkg;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 7;
	localparam int WORD_W  = 64;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	// Function codes of a request.
	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	// Status codes of a result.
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] word_in;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word_out;
		logic [COUNT_W-1:0] count;
		logic [STAT_W-1:0]  status;
	} rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [WORD_W-1:0] word;
	} cell_cmd_t;

endpackage

@@ rtl/iidl_cell.sv @@
// One storage cell of the list chain, holding the entry at a fixed index.
module iidl_cell #(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  logic                      clk,
	input  iidl_pkg::cell_cmd_t       cmd,
	input  logic [PW-1:0]             pos,
	input  logic [iidl_pkg::WORD_W-1:0] left,
	input  logic [iidl_pkg::WORD_W-1:0] right,
	output logic [iidl_pkg::WORD_W-1:0] data,
	output logic [iidl_pkg::WORD_W-1:0] hit
);
	import iidl_pkg::*;

	logic              at_pos;
	logic              above_pos;
	logic [WORD_W-1:0] data_q;

	assign at_pos    = (32'(pos) == 32'(IDX));
	assign above_pos = (32'(IDX) > 32'(pos));

	// On insert the cells above the index take their lower neighbor's entry and
	// the cell at the index takes the new word; on delete the cells from the
	// index upward take their upper neighbor's entry.
	always_ff @(posedge clk) begin
		priority if (cmd.ins && above_pos) begin
			data_q <= left;
		end else if (cmd.ins && at_pos) begin
			data_q <= cmd.word;
		end else if (cmd.del && (above_pos || at_pos)) begin
			data_q <= right;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;
	assign hit  = at_pos ? data_q : '0;

endmodule

@@ rtl/indexed_insert_delete_list_top.sv @@
// Top level of the indexed insert/delete list: request decode, fill count and cell chain.
//
// This block keeps an ordered list of up to DEPTH 64-bit words in a chain of
// cells, one cell per index. A request appends, inserts at an index, reads at
// an index, deletes at an index, or clears the list, and every request yields
// exactly one result with the word read, the entry count after the request and
// a status (done, index out of range, list full). Because every cell moves to
// its neighbor's entry in the same clock edge, the result appears in the
// output register on the cycle after the request is accepted, and a new
// request is taken in every cycle in which the output register is empty or
// its result is being taken. The rate is thus one request per cycle while
// results are taken, set by the whole chain shifting at once and the
// selection of the read entry across all cells. Out-of-range requests and
// appends or inserts on a full list change nothing. Entries above the current
// count hold no meaningful data and are never returned.
module indexed_insert_delete_list_top #(
	parameter int DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  iidl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output iidl_pkg::rsp_t rsp
);
	import iidl_pkg::*;

	// Fill counter width, and the width in which indexes and the count are compared.
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > POS_W) ? FW : POS_W;

	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     fill_d;
	logic [CW-1:0]     fill_c;
	logic [CW-1:0]     pos_c;
	logic [CW-1:0]     cell_pos;
	logic              full;
	logic              accept;
	logic              do_ins;
	logic              do_del;
	logic              rd_ok;
	logic [STAT_W-1:0] status;
	logic [WORD_W-1:0] rd_word;
	cell_cmd_t         cmd;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [WORD_W-1:0] cell_data [DEPTH];
	logic [WORD_W-1:0] cell_hit  [DEPTH];

	// The output register frees up when it is empty or its result leaves now.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign fill_c = CW'(fill_q);
	assign pos_c  = CW'(req.position);
	assign full   = (fill_q == FW'(DEPTH));

	// Request decode. An append is an insert at the current count. For an
	// insert the index check comes before the full check.
	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		rd_ok    = 1'b0;
		status   = ST_DONE;
		cell_pos = pos_c;
		fill_d   = fill_q;
		unique case (req.func)
			FN_APPEND: begin
				cell_pos = fill_c;
				if (full) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
					fill_d = fill_q + FW'(1);
				end
			end
			FN_INSERT: begin
				if (pos_c > fill_c) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
					fill_d = fill_q + FW'(1);
				end
			end
			FN_READ: begin
				if (pos_c >= fill_c) begin
					status = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			FN_DELETE: begin
				if (pos_c >= fill_c) begin
					status = ST_RANGE;
				end else begin
					do_del = 1'b1;
					fill_d = fill_q - FW'(1);
				end
			end
			FN_CLEAR: begin
				fill_d = '0;
			end
			default: begin
				// Unused function codes leave the list alone and report done.
			end
		endcase
	end

	// The chain only moves on an accepted request.
	assign cmd.ins  = accept && do_ins;
	assign cmd.del  = accept && do_del;
	assign cmd.word = req.word_in;

	// Cell chain: each cell sees its lower and upper neighbor. The lowest cell
	// never shifts up and the top cell shifts in an unused value on delete.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_data;
		logic [WORD_W-1:0] right_data;

		if (i == 0) begin : g_lo
			assign left_data = '0;
		end else begin : g_lo
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_hi
			assign right_data = '0;
		end else begin : g_hi
			assign right_data = cell_data[i+1];
		end

		iidl_cell #(
			.IDX (i),
			.PW  (CW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (cell_pos),
			.left  (left_data),
			.right (right_data),
			.data  (cell_data[i]),
			.hit   (cell_hit[i])
		);
	end

	// Only the cell at the read index drives a nonzero hit, so an OR across
	// the chain selects the read entry.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.word_out <= rd_ok ? rd_word : '0;
			rsp_q.count    <= COUNT_W'(fill_d);
			rsp_q.status   <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/iidl_checker.sv @@
// Port-level assertions for the indexed insert/delete list and their binding.
module iidl_checker #(
	parameter int DEPTH = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input iidl_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input iidl_pkg::rsp_t rsp
);
	import iidl_pkg::*;

	// Every accepted request shows its result in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result after an accepted request");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// The count never exceeds the list capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp.count) <= 32'(DEPTH)))
		else $error("count beyond capacity");

	// Only a successful read returns a nonzero word.
	a_word_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.func != FN_READ) |=> (rsp.word_out == '0))
		else $error("word returned for a request that is not a read");

	a_word_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |-> (rsp.word_out == '0))
		else $error("word returned with an error status");

endmodule

bind indexed_insert_delete_list_top iidl_checker #(.DEPTH(DEPTH)) u_iidl_checker (.*);

@@ test/tb_indexed_insert_delete_list_top.sv @@
// Self-checking testbench for the indexed insert/delete list top level.
module tb_indexed_insert_delete_list_top;

	import iidl_pkg::*;

	localparam int LIST_DEPTH  = 64;
	// Far above the slowest legal run: about 500 requests, each waiting out
	// long sender gaps and receiver stalls, plus one long receiver hold-off.
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SHOW_MAX    = 10;

	// The scoreboard keeps its own copy of the list contents and length. Every
	// accepted request is applied to that copy, and the response the block
	// should give is queued until the matching response comes out.
	class list_scoreboard;
		logic [WORD_W-1:0] words [LIST_DEPTH];
		int unsigned       length;
		rsp_t              awaited_results [$];
		int unsigned       mismatch_count;

		function new();
			length = 0;
			mismatch_count = 0;
		endfunction

		// Apply one request to the list copy and return the response it causes.
		function rsp_t apply_list_op(req_t r);
			rsp_t res;
			int   i;
			res = '0;
			res.status = ST_DONE;
			case (r.func)
				FN_APPEND: begin
					if (length >= LIST_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						words[length] = r.word_in;
						length++;
					end
				end
				FN_INSERT: begin
					// The index check wins over the full check.
					if (r.position > length) begin
						res.status = ST_RANGE;
					end else if (length >= LIST_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						for (i = length; i > r.position; i--)
							words[i] = words[i - 1];
						words[r.position] = r.word_in;
						length++;
					end
				end
				FN_READ: begin
					if (r.position >= length)
						res.status = ST_RANGE;
					else
						res.word_out = words[r.position];
				end
				FN_DELETE: begin
					if (r.position >= length) begin
						res.status = ST_RANGE;
					end else begin
						for (i = r.position + 1; i < length; i++)
							words[i - 1] = words[i];
						length--;
					end
				end
				FN_CLEAR: begin
					length = 0;
				end
				default: begin
				end
			endcase
			res.count = COUNT_W'(length);
			return res;
		endfunction

		function void note_request(req_t r);
			awaited_results.push_back(apply_list_op(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_MAX)
					$display("Response with no request pending: %s %h count %0d status %0d",
						"word", got.word_out, got.count, got.status);
				return;
			end
			want = awaited_results.pop_front();
			if (got.word_out !== want.word_out || got.count !== want.count ||
					got.status !== want.status) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_MAX)
					$display("Mismatch: expected word %h count %0d status %0d, %s",
						want.word_out, want.count, want.status,
						$sformatf("got word %h count %0d status %0d",
							got.word_out, got.count, got.status));
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Idle rates in percent for the request and response sides. Raising
	// hold_go starts one solid receiver hold-off, counted by the response side.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        hold_go       = 1'b0;
	int unsigned hold_count    = 0;
	int unsigned cycle_count   = 0;

	// sb tracks what the block has accepted; plan follows the requests as they
	// are generated so that indexes can be aimed at the current list length.
	list_scoreboard sb   = new();
	list_scoreboard plan = new();

	indexed_insert_delete_list_top #(
		.DEPTH(LIST_DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Monitor. All inputs change by nonblocking assignment at the edge, so
	// the values read here are the ones the block saw at this edge. A response
	// always belongs to a request taken at an earlier edge, so it is checked
	// before this edge's request is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if (req_valid && req_ready)
				sb.note_request(req);
		end
	end

	// Response side: random stalls at the current rate, or one solid hold-off,
	// counted in hold_count against HOLD_CYCLES, once hold_go is raised.
	always @(posedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			rsp_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one request and return at the edge where it is taken. Valid is
	// dropped only for a random gap before the request, so back-to-back
	// requests keep valid high without a second assignment in the same step.
	task automatic offer_request(input req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic issue_request(input logic [FUNC_W-1:0] fn, input int unsigned pos,
			input logic [WORD_W-1:0] word);
		req_t r;
		r.func = fn;
		r.position = POS_W'(pos);
		r.word_in = word;
		void'(plan.apply_list_op(r));
		offer_request(r);
	endtask

	// Random request shaped by the planned list length: grow_pct sets how
	// often the list grows, and most indexes land inside the list.
	function automatic req_t random_list_op(int unsigned grow_pct);
		req_t        r;
		int unsigned pick;
		int unsigned len;
		len = plan.length;
		r.word_in = {$urandom, $urandom};
		r.position = (len == 0) ? '0 : POS_W'($urandom_range(len - 1));
		pick = $urandom_range(99);
		if (pick < grow_pct) begin
			if ($urandom_range(1) == 1) begin
				r.func = FN_APPEND;
			end else begin
				r.func = FN_INSERT;
				r.position = POS_W'($urandom_range(len));
			end
		end else begin
			pick = $urandom_range(99);
			if (pick < 40)
				r.func = FN_READ;
			else if (pick < 92)
				r.func = FN_DELETE;
			else if (pick < 95)
				r.func = FN_CLEAR;
			else
				r.func = FUNC_W'($urandom_range(7, 5));
		end
		// Now and then an arbitrary index, which is mostly out of range.
		if ($urandom_range(99) < 12)
			r.position = POS_W'($urandom);
		return r;
	endfunction

	task automatic run_random(input int unsigned n, input int unsigned grow_pct);
		req_t r;
		repeat (n) begin
			r = random_list_op(grow_pct);
			void'(plan.apply_list_op(r));
			offer_request(r);
		end
	endtask

	// Stop offering and wait until every expected response has arrived.
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles lightly, receiver stalls heavily.
		send_idle_pct = 24;
		recv_idle_pct = 88;

		// Empty list: every indexed request is out of range, insert at zero works.
		issue_request(FN_READ,   0, '0);
		issue_request(FN_DELETE, 0, '0);
		issue_request(FN_INSERT, 1, 64'h1111_2222_3333_4444);
		issue_request(FN_INSERT, 0, '1);
		issue_request(FN_APPEND, 0, '0);
		issue_request(FN_APPEND, 0, 64'h0123_4567_89AB_CDEF);
		// Insert at the current length acts as an append.
		issue_request(FN_INSERT, 3, 64'hA5A5_A5A5_A5A5_A5A5);
		issue_request(FN_INSERT, 1, 64'h5A5A_5A5A_5A5A_5A5A);
		issue_request(FN_READ,   0, '0);
		issue_request(FN_READ,   4, '0);
		issue_request(FN_READ,   5, '0);
		issue_request(FN_READ,   127, '1);
		issue_request(FN_DELETE, 2, '0);
		issue_request(FN_DELETE, 3, '0);
		issue_request(FN_DELETE, 127, '0);
		issue_request(FN_INSERT, 64, '1);
		// Unused function codes leave the list alone.
		issue_request(3'd5, 1, '1);
		issue_request(3'd6, 0, 64'hDEAD_BEEF_0000_0001);
		issue_request(3'd7, 127, '1);
		issue_request(FN_CLEAR,  0, '0);
		issue_request(FN_READ,   0, '0);

		// Fill the list to the top, then hit the full-list cases.
		while (plan.length < LIST_DEPTH)
			issue_request(FN_APPEND, 0, {$urandom, $urandom});
		issue_request(FN_APPEND, 0, '1);
		issue_request(FN_INSERT, 0, '1);
		issue_request(FN_INSERT, LIST_DEPTH, '1);
		// Index past the end is reported ahead of the full condition.
		issue_request(FN_INSERT, LIST_DEPTH + 1, '1);
		issue_request(FN_READ,   LIST_DEPTH - 1, '0);
		issue_request(FN_DELETE, LIST_DEPTH - 1, '0);

		run_random(70, 75);
		run_random(50, 15);
		drain_results();

		// Phase two: the other way round.
		send_idle_pct = 88;
		recv_idle_pct = 24;
		run_random(70, 75);
		run_random(50, 15);
		drain_results();

		// Phase three: no idling. A long receiver hold-off lets the block fill
		// up and push back on the request side while requests keep coming.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_go = 1'b1;
		run_random(40, 60);
		run_random(70, 75);
		run_random(60, 15);
		drain_results();

		// Let any stray response show up before the verdict.
		repeat (8) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.awaited_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
